// ===== hdl/bpa_pkg.sv =====
// shared constants and types for the bitmap page allocator
package bpa_pkg;

  localparam int ADDR_W        = 64;
  localparam int WORD_BITS     = 64;
  localparam int BIT_W         = 6;
  localparam int PAGE_SHIFT    = 21;
  localparam int PCNT_W        = 13;
  localparam int CFG_IDX_W     = 1;
  localparam int DEF_MAX_PAGES = 4096;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_kind_t;

endpackage

// ===== hdl/bpa_front.sv =====
// front end: takes request words, turns free addresses into page indexes
module bpa_front import bpa_pkg::*; #(
  parameter int IDXW = 12,
  parameter int LIMW = 13
) (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tuser,
  input  logic [ADDR_W-1:0] in_tdata,
  input  logic [ADDR_W-1:0] heap_base,
  input  logic [LIMW-1:0]   limit,
  input  logic              q_full,
  input  logic              clearing,
  output logic              push,
  output logic [IDXW:0]     push_data
);

  localparam int PG_W = ADDR_W - PAGE_SHIFT;

  logic [ADDR_W-1:0] diff;
  logic [PG_W-1:0]   page;
  logic              in_range;
  cmd_kind_t         kind;

  assign kind      = cmd_kind_t'(in_tuser);
  assign diff      = in_tdata - heap_base;
  assign page      = diff[ADDR_W-1:PAGE_SHIFT];
  assign in_range  = page < PG_W'(limit);
  assign in_tready = !q_full && !clearing;

  // out of range frees are dropped here and never reach the back end
  assign push      = in_tvalid && in_tready && ((kind == CMD_ALLOC) || in_range);
  assign push_data = {kind, page[IDXW-1:0]};

endmodule

// ===== hdl/bpa_queue.sv =====
// two entry command queue between front and back
module bpa_queue #(
  parameter int W = 13
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         pop_valid,
  output logic [W-1:0] pop_data,
  input  logic         pop
);

  logic [W-1:0] entry_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign full      = cnt_r == 2'd2;
  assign pop_valid = cnt_r != 2'd0;
  assign pop_data  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/bpa_back.sv =====
// back end: bitmap memory, clear pass, first-fit word scan and result register
module bpa_back import bpa_pkg::*; #(
  parameter int MAX_PAGES = DEF_MAX_PAGES,
  parameter int WAW       = 6,
  parameter int IDXW      = 12,
  parameter int LIMW      = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ADDR_W-1:0] heap_base,
  input  logic [LIMW-1:0]   limit,
  input  logic              cmd_valid,
  input  logic [IDXW:0]     cmd_data,
  output logic              cmd_pop,
  output logic              clearing,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [ADDR_W-1:0] out_tdata,
  output logic              out_tuser
);

  localparam int WORD_COUNT = MAX_PAGES / WORD_BITS;
  localparam int WCW        = LIMW - BIT_W + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_GRANT
  } state_t;

  state_t            state_r, state_nxt;
  logic [WCW-1:0]    w_r, w_nxt;
  logic [WAW-1:0]    addr_r, addr_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic              out_grant_r, out_grant_nxt;

  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 wr_en;
  logic [WAW-1:0]       wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  cmd_kind_t            cmd_kind;
  logic [IDXW-1:0]      cmd_idx;
  logic [LIMW-BIT_W-1:0] lim_floor;
  logic                 lim_part;
  logic [WCW-1:0]       nwords;
  logic [WCW-1:0]       w_inc;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] freebits;
  logic [BIT_W-1:0]     first;
  logic [IDXW-1:0]      grant_idx;

  assign cmd_kind   = cmd_kind_t'(cmd_data[IDXW]);
  assign cmd_idx    = cmd_data[IDXW-1:0];
  assign lim_floor  = limit[LIMW-1:BIT_W];
  assign lim_part   = |limit[BIT_W-1:0];
  assign nwords     = WCW'(lim_floor) + WCW'(lim_part);
  assign w_inc      = w_r + WCW'(1);
  assign grant_idx  = {w_r[WAW-1:0], bit_r};

  assign clearing   = state_r == ST_CLEAR;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_grant_r;

  // last word may be only partly inside the page count
  always_comb begin
    if (lim_part && (w_r == WCW'(lim_floor))) begin
      mask = (WORD_BITS'(1) << limit[BIT_W-1:0]) - WORD_BITS'(1);
    end else begin
      mask = '1;
    end
    freebits = ~rd_data_r & mask;
  end

  // lowest set bit of the free mask
  always_comb begin
    first = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (freebits[i]) begin
        first = BIT_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    addr_nxt      = addr_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r;
    out_addr_nxt  = out_addr_r;
    out_grant_nxt = out_grant_r;
    cmd_pop       = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = addr_r;
    wr_data       = rd_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = w_r[WAW-1:0];
        wr_data = '0;
        if (w_r == WCW'(WORD_COUNT - 1)) begin
          w_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          w_nxt = w_inc;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd_kind == CMD_FREE) begin
            cmd_pop   = 1'b1;
            addr_nxt  = cmd_idx[IDXW-1:BIT_W];
            bit_nxt   = cmd_idx[BIT_W-1:0];
            state_nxt = ST_FREE_RD;
          end else if (!out_valid_r) begin
            cmd_pop  = 1'b1;
            w_nxt    = '0;
            addr_nxt = '0;
            if (limit == '0) begin
              out_valid_nxt = 1'b1;
              out_addr_nxt  = '0;
              out_grant_nxt = 1'b0;
            end else begin
              state_nxt = ST_SCAN_RD;
            end
          end
        end
      end
      ST_FREE_RD: begin
        state_nxt = ST_FREE_WR;
      end
      ST_FREE_WR: begin
        wr_en     = 1'b1;
        wr_data   = rd_data_r & ~(WORD_BITS'(1) << bit_r);
        state_nxt = ST_IDLE;
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (freebits != '0) begin
          bit_nxt   = first;
          state_nxt = ST_GRANT;
        end else if (w_inc < nwords) begin
          w_nxt     = w_inc;
          addr_nxt  = w_inc[WAW-1:0];
          state_nxt = ST_SCAN_RD;
        end else begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = '0;
          out_grant_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_GRANT: begin
        wr_en         = 1'b1;
        wr_data       = rd_data_r | (WORD_BITS'(1) << bit_r);
        out_valid_nxt = 1'b1;
        out_addr_nxt  = heap_base + (ADDR_W'(grant_idx) << PAGE_SHIFT);
        out_grant_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      w_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r      <= addr_nxt;
    bit_r       <= bit_nxt;
    out_addr_r  <= out_addr_nxt;
    out_grant_r <= out_grant_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[addr_r];
  end

endmodule

// ===== hdl/bitmap_page_allocator.sv =====
// First-fit allocator of 2 MiB pages over a used-bit bitmap held in a
// MAX_PAGES/64 word memory. After reset the bitmap memory is swept to zero,
// one word per cycle; no word is taken on in_ during that pass,
// configuration writes are taken as ever. Requests enter a two word queue,
// so in_ keeps accepting while the back end works or a result waits on
// out_, until the queue is full. A free reads, modifies and writes back one
// bitmap word and gives no result; a free outside the page count is dropped
// at the input. An alloc takes the request, then walks the bitmap one
// 64-page word at a time through the single memory read port, reading each
// word and then checking it, and finally marks the page and forms the
// address; when no page is free it returns a result with granted low.
// page_count above MAX_PAGES acts as MAX_PAGES.
module bitmap_page_allocator import bpa_pkg::*; #(
  parameter int MAX_PAGES = DEF_MAX_PAGES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [ADDR_W-1:0]    in_tdata,   // free_addr
  input  logic                 in_tuser,   // action
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [ADDR_W-1:0]    out_tdata,  // page_addr
  output logic                 out_tuser,  // granted
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  localparam int WORD_COUNT = MAX_PAGES / WORD_BITS;
  localparam int WAW  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int IDXW = WAW + BIT_W;
  localparam int LIMW = $clog2(MAX_PAGES + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = CFG_IDX_W'(1);

  logic [ADDR_W-1:0] heap_base_r;
  logic [PCNT_W-1:0] page_count_r;
  logic [LIMW-1:0]   limit;

  logic              q_full;
  logic              clearing;
  logic              push;
  logic [IDXW:0]     push_data;
  logic              pop_valid;
  logic [IDXW:0]     pop_data;
  logic              pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r  <= '0;
      page_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEAP_BASE:  heap_base_r  <= cfg_data;
        CFG_PAGE_COUNT: page_count_r <= cfg_data[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign limit = (32'(page_count_r) > 32'(MAX_PAGES)) ? LIMW'(MAX_PAGES)
                                                      : LIMW'(page_count_r);

  bpa_front #(
    .IDXW (IDXW),
    .LIMW (LIMW)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .heap_base (heap_base_r),
    .limit     (limit),
    .q_full    (q_full),
    .clearing  (clearing),
    .push      (push),
    .push_data (push_data)
  );

  bpa_queue #(
    .W (IDXW + 1)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop)
  );

  bpa_back #(
    .MAX_PAGES (MAX_PAGES),
    .WAW       (WAW),
    .IDXW      (IDXW),
    .LIMW      (LIMW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .heap_base  (heap_base_r),
    .limit      (limit),
    .cmd_valid  (pop_valid),
    .cmd_data   (pop_data),
    .cmd_pop    (pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
